### hdl/mmc_pkg.sv
// Shared types and constants of the mini MIPS instruction core.
`default_nettype none
package mmc_pkg;

   localparam int PC_BITS    = 12;
   localparam int DMEM_DEPTH = 256;
   localparam int DMEM_AW    = 8;
   localparam int REGFILE_DEPTH = 8;
   localparam int REG_AW     = 3;
   localparam int OUT_BITS   = 8;
   localparam int COUNT_BITS = 9;
   localparam int IMM_BITS   = 6;

   typedef enum logic [1:0] {
      REQ_LOAD      = 2'd0,
      REQ_STEP      = 2'd1,
      REQ_READ_DATA = 2'd2,
      REQ_READ_REG  = 2'd3
   } req_code_type;

   localparam logic [3:0] OP_RTYPE = 4'd0;
   localparam logic [3:0] OP_J     = 4'd2;
   localparam logic [3:0] OP_J_ALT = 4'd3;
   localparam logic [3:0] OP_LW    = 4'd4;
   localparam logic [3:0] OP_SW    = 4'd5;
   localparam logic [3:0] OP_ADDI  = 4'd8;
   localparam logic [3:0] OP_BEQ   = 4'd10;

   localparam logic [2:0] FN_ADD = 3'd0;
   localparam logic [2:0] FN_SUB = 3'd1;
   localparam logic [2:0] FN_AND = 3'd2;
   localparam logic [2:0] FN_OR  = 3'd3;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [DMEM_AW-1:0]   addr;
   } dmem_ctl_type;

endpackage
`default_nettype wire

### hdl/mmc_req_if.sv
// Request channel of the mini MIPS instruction core.
`default_nettype none
interface mmc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] instr_word;
   logic [7:0]  query_index;

   modport source (output valid, output req_type, output instr_word, output query_index,
                   input ready);
   modport sink (input valid, input req_type, input instr_word, input query_index,
                 output ready);
endinterface
`default_nettype wire

### hdl/mmc_rsp_if.sv
// Result channel of the mini MIPS instruction core.
`default_nettype none
interface mmc_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        step_pc;
   logic               program_ended;
   logic               reg_write;
   logic [2:0]         reg_number;
   logic               mem_write;
   logic [7:0]         mem_address;
   logic               branch_taken;
   logic signed [7:0]  value;
   logic [8:0]         loaded_count;

   modport source (output valid, output step_pc, output program_ended, output reg_write,
                   output reg_number, output mem_write, output mem_address,
                   output branch_taken, output value, output loaded_count, input ready);
   modport sink (input valid, input step_pc, input program_ended, input reg_write,
                 input reg_number, input mem_write, input mem_address,
                 input branch_taken, input value, input loaded_count, output ready);
endinterface
`default_nettype wire

### hdl/mmc_imem.sv
// Instruction memory with registered fetch and write-to-fetch bypass.
`default_nettype none
module mmc_imem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [15:0]        rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;
   logic        byp_ff;
   logic        byp_in;
   logic [15:0] byp_word_ff;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      byp_ff      <= byp_in;
      byp_word_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_word_ff : rd_data_ff;

endmodule
`default_nettype wire

### hdl/mmc_dmem.sv
// Data memory with per-word valid bits so that unwritten words read as zero.
`default_nettype none
module mmc_dmem #(
   parameter int WB = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mmc_pkg::dmem_ctl_type ctl,
   input  wire logic [WB-1:0]        wr_data,
   output logic [WB-1:0]             rd_data
);

   logic [WB-1:0]                   mem [mmc_pkg::DMEM_DEPTH];
   logic [mmc_pkg::DMEM_DEPTH-1:0]  valid_ff;
   logic [WB-1:0]                   rd_data_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

### hdl/mini_mips_16bit_instruction_core.sv
// Top level of the mini MIPS instruction core: request register, execute, result register.
//
//  channel   | dir | handshake   | payload
//  req_chan  | in  | valid/ready | req_type, instr_word, query_index
//  rsp_chan  | out | valid/ready | step_pc, program_ended, reg_write, reg_number,
//            |     |             | mem_write, mem_address, branch_taken, value, loaded_count
//
// One request per cycle while results are taken; a result passes through the request register
// and then the result register (the data memory read is registered alongside the result register).
// The fetch register is refilled every cycle from the next program counter.
// Reset clears pc, program size, registers and the data memory valid bits at once.
// While a result is held, the request register holds and ready drops once it is full.
`default_nettype none
module mini_mips_16bit_instruction_core #(
   parameter int IMEM_DEPTH = 256,
   parameter int WORD_BITS  = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   mmc_req_if.sink   req_chan,
   mmc_rsp_if.source rsp_chan
);

   localparam int PCB  = mmc_pkg::PC_BITS;
   localparam int IAW  = (IMEM_DEPTH > 1) ? $clog2(IMEM_DEPTH) : 1;
   localparam int SW   = $clog2(IMEM_DEPTH + 1);
   localparam int CMPW = (SW > PCB) ? SW : PCB;
   localparam int WB   = WORD_BITS;
   localparam int IMB  = mmc_pkg::IMM_BITS;
   localparam int CNTW = mmc_pkg::COUNT_BITS;

   // request register
   logic                  e1_valid_ff, e1_valid_in;
   mmc_pkg::req_code_type e1_type_ff;
   logic [15:0]           e1_word_ff;
   logic [7:0]            e1_qidx_ff;

   // architectural state
   logic [PCB-1:0]  pc_ff, pc_in;
   logic [SW-1:0]   size_ff, size_in;
   logic [WB-1:0]   regs_ff [mmc_pkg::REGFILE_DEPTH];

   // result register
   logic                         e2_valid_ff, e2_valid_in;
   logic [PCB-1:0]               step_pc_ff;
   logic                         ended_ff, rw_ff, mw_ff, taken_ff, from_mem_ff;
   logic [mmc_pkg::REG_AW-1:0]   rnum_ff;
   logic [mmc_pkg::DMEM_AW-1:0]  maddr_ff;
   logic [WB-1:0]                value_ff;
   logic [CNTW-1:0]              count_ff;

   logic req_fire, rsp_fire, advance, e1_fire;
   logic [WB-1:0] e2_word, dmem_rdata;
   logic [15:0]   instr;

   // decode and execute
   logic [3:0]                 op;
   logic [mmc_pkg::REG_AW-1:0] rs, rt, rd;
   logic [2:0]                 funct;
   logic [IMB-1:0]             imm;
   logic [WB-1:0]              imm_w, rs_val, rt_val, q_val, sum, alu_val;
   logic [PCB-1:0]             imm_pc, next_pc;
   logic                       is_step, ended, exec;
   logic                       rw_n, mw_n, taken_n, from_mem_n, ld_we;
   logic [mmc_pkg::REG_AW-1:0] rnum_n;
   logic [mmc_pkg::DMEM_AW-1:0] maddr_n;
   logic [WB-1:0]              value_n;
   logic [SW-1:0]              size_after;
   logic [SW+CNTW-1:0]         size_wide;
   mmc_pkg::dmem_ctl_type      dmem_ctl;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign advance  = !e2_valid_ff || rsp_chan.ready;
   assign e1_fire  = e1_valid_ff && advance;
   assign req_chan.ready = !e1_valid_ff || advance;

   assign e1_valid_in = req_fire ? 1'b1 : (e1_fire ? 1'b0 : e1_valid_ff);
   assign e2_valid_in = e1_fire ? 1'b1 : (rsp_fire ? 1'b0 : e2_valid_ff);

   assign e2_word = from_mem_ff ? dmem_rdata : value_ff;

   function automatic logic [WB-1:0] read_reg(input logic [mmc_pkg::REG_AW-1:0] idx);
      logic hit;
      hit = e2_valid_ff && rw_ff && (rnum_ff == idx);
      return hit ? e2_word : regs_ff[idx];
   endfunction

   always_comb begin
      op     = instr[15:12];
      rs     = instr[11:9];
      rt     = instr[8:6];
      rd     = instr[5:3];
      funct  = instr[2:0];
      imm    = instr[IMB-1:0];
      imm_w  = {{(WB-IMB){imm[IMB-1]}}, imm};
      imm_pc = {{(PCB-IMB){imm[IMB-1]}}, imm};
      rs_val = read_reg(rs);
      rt_val = read_reg(rt);
      q_val  = read_reg(e1_qidx_ff[mmc_pkg::REG_AW-1:0]);
      sum    = rs_val + imm_w;

      case (funct)
         mmc_pkg::FN_ADD: alu_val = rs_val + rt_val;
         mmc_pkg::FN_SUB: alu_val = rs_val - rt_val;
         mmc_pkg::FN_AND: alu_val = rs_val & rt_val;
         mmc_pkg::FN_OR:  alu_val = rs_val | rt_val;
         default:         alu_val = '0;
      endcase

      is_step = (e1_type_ff == mmc_pkg::REQ_STEP);
      ended   = is_step && (CMPW'(pc_ff) >= CMPW'(size_ff));
      exec    = is_step && !ended;

      rw_n       = 1'b0;
      mw_n       = 1'b0;
      taken_n    = 1'b0;
      from_mem_n = 1'b0;
      rnum_n     = '0;
      maddr_n    = '0;
      value_n    = '0;
      next_pc    = pc_ff + PCB'(1);

      if (exec) begin
         case (op)
            mmc_pkg::OP_RTYPE: begin
               rw_n    = 1'b1;
               rnum_n  = rd;
               value_n = alu_val;
            end
            mmc_pkg::OP_J, mmc_pkg::OP_J_ALT: begin
               next_pc = instr[PCB-1:0];
            end
            mmc_pkg::OP_LW: begin
               maddr_n    = sum[mmc_pkg::DMEM_AW-1:0];
               rw_n       = 1'b1;
               rnum_n     = rt;
               from_mem_n = 1'b1;
            end
            mmc_pkg::OP_SW: begin
               maddr_n = sum[mmc_pkg::DMEM_AW-1:0];
               mw_n    = 1'b1;
               value_n = rt_val;
            end
            mmc_pkg::OP_ADDI: begin
               rw_n    = 1'b1;
               rnum_n  = rt;
               value_n = sum;
            end
            mmc_pkg::OP_BEQ: begin
               if (rs_val == rt_val) begin
                  taken_n = 1'b1;
                  next_pc = pc_ff + imm_pc;
               end
            end
            default: begin
            end
         endcase
      end else if (e1_type_ff == mmc_pkg::REQ_READ_DATA) begin
         from_mem_n = 1'b1;
      end else if (e1_type_ff == mmc_pkg::REQ_READ_REG) begin
         value_n = q_val;
      end

      ld_we      = e1_fire && (e1_type_ff == mmc_pkg::REQ_LOAD) && (size_ff < SW'(IMEM_DEPTH));
      size_after = ld_we ? size_ff + SW'(1) : size_ff;
      size_in    = size_after;
      size_wide  = (SW + CNTW)'(size_after);
      pc_in      = (e1_fire && exec) ? next_pc : pc_ff;

      dmem_ctl.rd_en = e1_fire && from_mem_n;
      dmem_ctl.wr_en = e1_fire && mw_n;
      dmem_ctl.addr  = (e1_type_ff == mmc_pkg::REQ_READ_DATA) ? e1_qidx_ff : maddr_n;
   end

   mmc_imem #(
      .DEPTH (IMEM_DEPTH),
      .AW    (IAW)
   ) u_imem (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (size_ff[IAW-1:0]),
      .wr_data (e1_word_ff),
      .rd_addr (pc_in[IAW-1:0]),
      .rd_data (instr)
   );

   mmc_dmem #(
      .WB (WB)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dmem_ctl),
      .wr_data (rt_val),
      .rd_data (dmem_rdata)
   );

   always_ff @(posedge clock) begin
      if (req_fire) begin
         e1_type_ff <= mmc_pkg::req_code_type'(req_chan.req_type);
         e1_word_ff <= req_chan.instr_word;
         e1_qidx_ff <= req_chan.query_index;
      end
      if (e1_fire) begin
         step_pc_ff  <= pc_ff;
         ended_ff    <= ended;
         rw_ff       <= rw_n;
         rnum_ff     <= rnum_n;
         mw_ff       <= mw_n;
         maddr_ff    <= maddr_n;
         taken_ff    <= taken_n;
         value_ff    <= value_n;
         from_mem_ff <= from_mem_n;
         count_ff    <= size_wide[CNTW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         pc_ff       <= '0;
         size_ff     <= '0;
         for (int i = 0; i < mmc_pkg::REGFILE_DEPTH; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         e1_valid_ff <= e1_valid_in;
         e2_valid_ff <= e2_valid_in;
         pc_ff       <= pc_in;
         size_ff     <= size_in;
         if (e2_valid_ff && rw_ff) begin
            regs_ff[rnum_ff] <= e2_word;
         end
      end
   end

   assign rsp_chan.valid         = e2_valid_ff;
   assign rsp_chan.step_pc       = step_pc_ff;
   assign rsp_chan.program_ended = ended_ff;
   assign rsp_chan.reg_write     = rw_ff;
   assign rsp_chan.reg_number    = rnum_ff;
   assign rsp_chan.mem_write     = mw_ff;
   assign rsp_chan.mem_address   = maddr_ff;
   assign rsp_chan.branch_taken  = taken_ff;
   assign rsp_chan.value         = e2_word[mmc_pkg::OUT_BITS-1:0];
   assign rsp_chan.loaded_count  = count_ff;

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SW'(IMEM_DEPTH))
      else $error("program size past instruction memory depth");

   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      ld_we |=> size_ff == $past(size_ff) + SW'(1))
      else $error("accepted load did not grow program size");

   a_ended_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.program_ended |->
         !rsp_chan.reg_write && !rsp_chan.mem_write && !rsp_chan.branch_taken)
      else $error("ended step reports side effects");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.reg_write && rsp_chan.mem_write))
      else $error("step wrote both register and memory");

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !(e1_fire && exec) |=> $stable(pc_ff))
      else $error("pc moved without an executed step");

endmodule
`default_nettype wire
